// ----- design/nsfe_pkg.sv -----
// Shared constants and types for the NMEA sentence field extractor.
package nsfe_pkg;

  // Slot organization and storage sizes.
  localparam int LONG_SLOTS  = 3;
  localparam int SHORT_SLOTS = 3;
  localparam int ALL_SLOTS   = LONG_SLOTS + SHORT_SLOTS;
  localparam int LONG_LEN    = 14;

  // Field widths of the streams and of the configuration port.
  localparam int SEL_W   = 5;
  localparam int CHAR_W  = 8;
  localparam int FCNT_W  = 8;
  localparam int POS_W   = 4;
  localparam int RSLOT_W = 3;
  localparam int CFGA_W  = 3;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 32;

  // Characters that steer the parser.
  localparam logic [CHAR_W-1:0] CH_G     = 8'h47;
  localparam logic [CHAR_W-1:0] CH_A     = 8'h41;
  localparam logic [CHAR_W-1:0] CH_R     = 8'h52;
  localparam logic [CHAR_W-1:0] CH_M     = 8'h4D;
  localparam logic [CHAR_W-1:0] CH_C     = 8'h43;
  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_QMARK = 8'h3F;

  // Input action codes.
  localparam logic ACT_RECEIVE = 1'b0;
  localparam logic ACT_READ    = 1'b1;

  // One result item as it sits in the output register.
  typedef struct packed {
    logic                   done;
    logic                   kind;
    logic [ALL_SLOTS-1:0]   hits;
    logic [FCNT_W-1:0]      fnum;
    logic [CHAR_W-1:0]      rchar;
    logic [POS_W-1:0]       rlen;
  } nsfe_result_t;

endpackage

// ----- design/nmea_sentence_field_extractor.sv -----
// Top level of the NMEA GGA/RMC sentence field extractor.
//
// Usage: each transfer on the in_ channel carries one item. With in_tuser low
// the item is a received UART byte with its line-error flag; the parser hunts
// for the tags GGA or RMC, a comma, then counts comma-separated fields until
// '*'. Characters of fields named by the six slot registers are stored. With
// in_tuser high the item reads the stored contents of one slot instead.
// Every item yields exactly one transfer on the out_ channel; out_tlast marks
// the '*' that ended a sentence.
// Timing: an item passes one input register, then the parse and slot update
// feed the output register. A new item is taken in every cycle while the
// output is not stalled; the sustained rate is then one item per cycle, set
// by the parser state update, which is registered with each item.
// Reset (rst_n low, synchronous) returns the parser to hunting, clears the
// counters and lengths, fills the short slots with '?' and loads the default
// slot selections. When out_tready is low the result is held, the input
// register still fills once, and in_tready then drops until the output moves.
// The cfg_ port writes a slot selection; a changed value clears that slot.
module nmea_sentence_field_extractor (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input stream.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // in_tdata: rx_byte[7:0], line_error[8], read_slot[11:9], read_pos[15:12]
  input  logic [nsfe_pkg::IN_TDATA_W-1:0]   in_tdata,
  // in_tuser: action[0]
  input  logic                              in_tuser,
  // Result stream.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_tdata: hit_mask[5:0], field_number[13:6], read_char[21:14],
  //            read_length[25:22], zero fill[31:26]
  output logic [nsfe_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // out_tuser: sentence_kind[0]
  output logic                              out_tuser,
  // out_tlast: sentence_done
  output logic                              out_tlast,
  // Configuration write port.
  input  logic                              cfg_we,
  input  logic [nsfe_pkg::CFGA_W-1:0]       cfg_addr,
  input  logic [nsfe_pkg::SEL_W-1:0]        cfg_wdata
);
  import nsfe_pkg::*;

  // Parser phases.
  localparam logic [2:0] PH_HUNT   = 3'd0;
  localparam logic [2:0] PH_GGA2   = 3'd1;
  localparam logic [2:0] PH_GGA3   = 3'd2;
  localparam logic [2:0] PH_RMC2   = 3'd3;
  localparam logic [2:0] PH_RMC3   = 3'd4;
  localparam logic [2:0] PH_COMMA  = 3'd5;
  localparam logic [2:0] PH_FIELDS = 3'd6;

  localparam int LIDX_W = $clog2(LONG_SLOTS) > 0 ? $clog2(LONG_SLOTS) : 1;
  localparam int SIDX_W = $clog2(SHORT_SLOTS) > 0 ? $clog2(SHORT_SLOTS) : 1;
  localparam logic [POS_W-1:0] LONG_MAX = POS_W'(LONG_LEN - 1);

  // Input register.
  logic                 s1_valid_r;
  logic                 s1_act_r;
  logic [CHAR_W-1:0]    s1_byte_r;
  logic                 s1_lerr_r;
  logic [RSLOT_W-1:0]   s1_rslot_r;
  logic [POS_W-1:0]     s1_rpos_r;
  logic                 s1_go;

  // Output register.
  logic                 out_valid_r;
  nsfe_result_t         res_r;
  nsfe_result_t         res_nxt;

  // Parser and slot state.
  logic [2:0]           phase_r, phase_nxt;
  logic                 kind_r, kind_nxt;
  logic [FCNT_W-1:0]    fcnt_r, fcnt_nxt;
  logic [SEL_W-1:0]     sel_r    [ALL_SLOTS];
  logic [POS_W-1:0]     widx_r   [LONG_SLOTS];
  logic [POS_W-1:0]     widx_nxt [LONG_SLOTS];
  logic [POS_W-1:0]     vlen_r   [LONG_SLOTS];
  logic [POS_W-1:0]     vlen_nxt [LONG_SLOTS];
  logic [CHAR_W-1:0]    schar_r  [SHORT_SLOTS];
  logic [CHAR_W-1:0]    schar_nxt[SHORT_SLOTS];
  logic [CHAR_W-1:0]    lchar_r  [LONG_SLOTS][LONG_LEN];
  logic [LONG_SLOTS-1:0] lwe;

  // The input register moves on when the output register is empty or drained.
  assign s1_go     = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_go;

  // A slot matches when it is enabled and names the current kind and field.
  function automatic logic slot_hit(input logic [SEL_W-1:0] sel, input logic kind,
                                    input logic [FCNT_W-1:0] fcnt);
    slot_hit = (sel[3:0] != 4'd0) && (sel[4] == kind) &&
               ({{(FCNT_W-4){1'b0}}, sel[3:0]} == fcnt);
  endfunction

  always_comb begin
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    fcnt_nxt  = fcnt_r;
    widx_nxt  = widx_r;
    vlen_nxt  = vlen_r;
    schar_nxt = schar_r;
    lwe       = '0;
    res_nxt   = '0;

    if (s1_act_r == ACT_READ) begin
      if (s1_rslot_r < RSLOT_W'(LONG_SLOTS)) begin
        res_nxt.rlen = vlen_r[s1_rslot_r[LIDX_W-1:0]];
        if ((s1_rpos_r < res_nxt.rlen) && (s1_rpos_r < POS_W'(LONG_LEN))) begin
          res_nxt.rchar = lchar_r[s1_rslot_r[LIDX_W-1:0]][s1_rpos_r];
        end
      end else if (s1_rslot_r < RSLOT_W'(ALL_SLOTS)) begin
        res_nxt.rchar = schar_r[SIDX_W'(s1_rslot_r - RSLOT_W'(LONG_SLOTS))];
        res_nxt.rlen  = POS_W'(1);
      end
    end else if (s1_lerr_r) begin
      // A corrupted byte is dropped and the sentence is abandoned.
      phase_nxt = PH_HUNT;
    end else begin
      case (phase_r)
        PH_HUNT: begin
          if (s1_byte_r == CH_G) begin
            phase_nxt = PH_GGA2;
          end else if (s1_byte_r == CH_R) begin
            phase_nxt = PH_RMC2;
          end
        end
        PH_GGA2: phase_nxt = (s1_byte_r == CH_G) ? PH_GGA3 : PH_HUNT;
        PH_RMC2: phase_nxt = (s1_byte_r == CH_M) ? PH_RMC3 : PH_HUNT;
        PH_GGA3, PH_RMC3: begin
          if ((phase_r == PH_GGA3 && s1_byte_r == CH_A) ||
              (phase_r == PH_RMC3 && s1_byte_r == CH_C)) begin
            phase_nxt = PH_COMMA;
            kind_nxt  = (phase_r == PH_RMC3);
            fcnt_nxt  = FCNT_W'(1);
            for (int s = 0; s < LONG_SLOTS; s++) widx_nxt[s] = '0;
          end else begin
            phase_nxt = PH_HUNT;
          end
        end
        PH_COMMA: begin
          if (s1_byte_r == CH_COMMA) begin
            phase_nxt = PH_FIELDS;
            fcnt_nxt  = FCNT_W'(1);
            for (int s = 0; s < LONG_SLOTS; s++) widx_nxt[s] = '0;
          end else begin
            phase_nxt = PH_HUNT;
          end
        end
        PH_FIELDS: begin
          if (s1_byte_r == CH_STAR) begin
            res_nxt.done = 1'b1;
            phase_nxt    = PH_HUNT;
          end else if (s1_byte_r == CH_COMMA) begin
            if (fcnt_r != '1) fcnt_nxt = fcnt_r + FCNT_W'(1);
          end else begin
            for (int s = 0; s < LONG_SLOTS; s++) begin
              if (slot_hit(sel_r[s], kind_r, fcnt_r) && (widx_r[s] < LONG_MAX)) begin
                lwe[s]          = 1'b1;
                widx_nxt[s]     = widx_r[s] + POS_W'(1);
                vlen_nxt[s]     = widx_r[s] + POS_W'(1);
                res_nxt.hits[s] = 1'b1;
              end
            end
            for (int s = 0; s < SHORT_SLOTS; s++) begin
              if (slot_hit(sel_r[LONG_SLOTS+s], kind_r, fcnt_r)) begin
                schar_nxt[s]               = s1_byte_r;
                res_nxt.hits[LONG_SLOTS+s] = 1'b1;
              end
            end
          end
        end
        default: phase_nxt = PH_HUNT;
      endcase
    end

    // Kind and field number are reported after this item's update.
    res_nxt.kind = kind_nxt;
    res_nxt.fnum = fcnt_nxt;
  end

  // Handshake registers and the captured input item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) s1_valid_r <= in_tvalid;
      if (s1_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_act_r   <= in_tuser;
      s1_byte_r  <= in_tdata[7:0];
      s1_lerr_r  <= in_tdata[8];
      s1_rslot_r <= in_tdata[11:9];
      s1_rpos_r  <= in_tdata[15:12];
    end
    if (s1_go) res_r <= res_nxt;
  end

  // Parser state, slot selections and slot contents. Configuration writes must
  // arrive only while no item is in flight; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      kind_r  <= 1'b0;
      fcnt_r  <= '0;
      for (int s = 0; s < ALL_SLOTS; s++) sel_r[s] <= '0;
      if (LONG_SLOTS > 2) sel_r[2] <= SEL_W'(1);
      for (int s = 0; s < LONG_SLOTS; s++) begin
        widx_r[s] <= '0;
        vlen_r[s] <= '0;
      end
      for (int s = 0; s < SHORT_SLOTS; s++) schar_r[s] <= CH_QMARK;
    end else if (cfg_we) begin
      if ((cfg_addr < CFGA_W'(ALL_SLOTS)) && (sel_r[cfg_addr] != cfg_wdata)) begin
        sel_r[cfg_addr] <= cfg_wdata;
        phase_r         <= PH_HUNT;
        if (cfg_addr < CFGA_W'(LONG_SLOTS)) begin
          widx_r[cfg_addr[LIDX_W-1:0]] <= '0;
          vlen_r[cfg_addr[LIDX_W-1:0]] <= '0;
        end else begin
          schar_r[SIDX_W'(cfg_addr - CFGA_W'(LONG_SLOTS))] <= CH_QMARK;
        end
      end
    end else if (s1_go) begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      fcnt_r  <= fcnt_nxt;
      widx_r  <= widx_nxt;
      vlen_r  <= vlen_nxt;
      schar_r <= schar_nxt;
    end
  end

  // Long slot character storage, one write port per slot.
  always_ff @(posedge clk) begin
    if (s1_go && !cfg_we) begin
      for (int s = 0; s < LONG_SLOTS; s++) begin
        if (lwe[s]) lchar_r[s][widx_r[s]] <= s1_byte_r;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = res_r.done;
  assign out_tuser  = res_r.kind;
  assign out_tdata  = {{(OUT_TDATA_W - ALL_SLOTS - FCNT_W - CHAR_W - POS_W){1'b0}},
                       res_r.rlen, res_r.rchar, res_r.fnum, res_r.hits};

endmodule

// ----- bench/nsfe_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the NMEA field extractor: predicts every result and compares it.
module nsfe_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [nsfe_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                              in_tuser,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [nsfe_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                              out_tuser,
  input  logic                              out_tlast,
  input  logic                              cfg_we,
  input  logic [nsfe_pkg::CFGA_W-1:0]       cfg_addr,
  input  logic [nsfe_pkg::SEL_W-1:0]        cfg_wdata,
  output int                                fail_count,
  output int                                pending
);
  import nsfe_pkg::*;

  typedef enum logic [2:0] {
    HUNT, GGA_2, GGA_3, RMC_2, RMC_3, TAG_COMMA, IN_FIELDS
  } parse_state_t;

  logic [SEL_W-1:0]  slot_sel [ALL_SLOTS];
  parse_state_t      pstate;
  logic              cur_kind;
  logic [FCNT_W-1:0] fcnt;
  logic [POS_W-1:0]  widx [LONG_SLOTS];
  logic [POS_W-1:0]  vlen [LONG_SLOTS];
  logic [CHAR_W-1:0] long_text [LONG_SLOTS][LONG_LEN];
  logic [CHAR_W-1:0] short_text [SHORT_SLOTS];

  nsfe_result_t      due_results [$];

  function automatic void clear_parser();
    for (int s = 0; s < ALL_SLOTS; s++) slot_sel[s] = '0;
    slot_sel[2] = 5'd1;
    pstate   = HUNT;
    cur_kind = 1'b0;
    fcnt     = '0;
    for (int s = 0; s < LONG_SLOTS; s++) begin
      widx[s] = '0;
      vlen[s] = '0;
      for (int p = 0; p < LONG_LEN; p++) long_text[s][p] = '0;
    end
    for (int s = 0; s < SHORT_SLOTS; s++) short_text[s] = CH_QMARK;
  endfunction

  // A changed selection empties its slot and drops the parser back to hunting.
  function automatic void select_slot(input logic [CFGA_W-1:0] idx,
                                      input logic [SEL_W-1:0] value);
    if (idx < ALL_SLOTS && slot_sel[idx] != value) begin
      slot_sel[idx] = value;
      if (idx < LONG_SLOTS) begin
        widx[idx] = '0;
        vlen[idx] = '0;
      end else begin
        short_text[idx - LONG_SLOTS] = CH_QMARK;
      end
      pstate = HUNT;
    end
  endfunction

  function automatic void open_sentence();
    fcnt = 8'd1;
    for (int s = 0; s < LONG_SLOTS; s++) widx[s] = '0;
  endfunction

  function automatic logic slot_wants(input int s);
    logic [SEL_W-1:0] sel;
    sel = slot_sel[s];
    return sel[3:0] != 4'd0 && sel[4] == cur_kind && fcnt == {4'd0, sel[3:0]};
  endfunction

  function automatic nsfe_result_t parse_item(input logic act,
                                              input logic [IN_TDATA_W-1:0] d);
    nsfe_result_t      r;
    logic [CHAR_W-1:0] b;
    logic              lerr;
    logic [RSLOT_W-1:0] rs;
    logic [POS_W-1:0]  rp;
    r    = '0;
    b    = d[7:0];
    lerr = d[8];
    rs   = d[11:9];
    rp   = d[15:12];
    if (act == ACT_READ) begin
      if (rs < LONG_SLOTS) begin
        r.rlen = vlen[rs];
        if (rp < vlen[rs]) r.rchar = long_text[rs][rp];
      end else if (rs < ALL_SLOTS) begin
        r.rchar = short_text[rs - LONG_SLOTS];
        r.rlen  = 4'd1;
      end
    end else if (lerr) begin
      pstate = HUNT;
    end else begin
      case (pstate)
        HUNT: begin
          if (b == CH_G) pstate = GGA_2;
          else if (b == CH_R) pstate = RMC_2;
        end
        GGA_2: pstate = (b == CH_G) ? GGA_3 : HUNT;
        GGA_3: begin
          if (b == CH_A) begin
            pstate   = TAG_COMMA;
            cur_kind = 1'b0;
            open_sentence();
          end else begin
            pstate = HUNT;
          end
        end
        RMC_2: pstate = (b == CH_M) ? RMC_3 : HUNT;
        RMC_3: begin
          if (b == CH_C) begin
            pstate   = TAG_COMMA;
            cur_kind = 1'b1;
            open_sentence();
          end else begin
            pstate = HUNT;
          end
        end
        TAG_COMMA: begin
          if (b == CH_COMMA) begin
            pstate = IN_FIELDS;
            open_sentence();
          end else begin
            pstate = HUNT;
          end
        end
        IN_FIELDS: begin
          if (b == CH_STAR) begin
            r.done = 1'b1;
            pstate = HUNT;
          end else if (b == CH_COMMA) begin
            if (fcnt != 8'hFF) fcnt = fcnt + 8'd1;
          end else begin
            for (int s = 0; s < ALL_SLOTS; s++) begin
              if (slot_wants(s)) begin
                if (s < LONG_SLOTS) begin
                  // Characters beyond the slot capacity are dropped.
                  if (widx[s] < LONG_LEN - 1) begin
                    long_text[s][widx[s]] = b;
                    widx[s] = widx[s] + 4'd1;
                    vlen[s] = widx[s];
                    r.hits[s] = 1'b1;
                  end
                end else begin
                  short_text[s - LONG_SLOTS] = b;
                  r.hits[s] = 1'b1;
                end
              end
            end
          end
        end
        default: pstate = HUNT;
      endcase
    end
    r.kind = cur_kind;
    r.fnum = fcnt;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
    fail_count++;
  endtask

  task automatic check_result(input nsfe_result_t want);
    if (out_tlast !== want.done)
      report_mismatch("sentence_done", 32'(out_tlast), 32'(want.done));
    if (out_tuser !== want.kind)
      report_mismatch("sentence_kind", 32'(out_tuser), 32'(want.kind));
    if (out_tdata[5:0] !== want.hits)
      report_mismatch("hit_mask", 32'(out_tdata[5:0]), 32'(want.hits));
    if (out_tdata[13:6] !== want.fnum)
      report_mismatch("field_number", 32'(out_tdata[13:6]), 32'(want.fnum));
    if (out_tdata[21:14] !== want.rchar)
      report_mismatch("read_char", 32'(out_tdata[21:14]), 32'(want.rchar));
    if (out_tdata[25:22] !== want.rlen)
      report_mismatch("read_length", 32'(out_tdata[25:22]), 32'(want.rlen));
    if (out_tdata[31:26] !== 6'd0)
      report_mismatch("zero fill", 32'(out_tdata[31:26]), 32'd0);
  endtask

  // Results are retired before new items are queued, so an early result can
  // never be matched against the item accepted at the same edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parser();
      due_results.delete();
    end else begin
      if (cfg_we) select_slot(cfg_addr, cfg_wdata);
      if (out_tvalid && out_tready) begin
        if (due_results.size() == 0) report_mismatch("unexpected result", out_tdata, 32'd0);
        else check_result(due_results.pop_front());
      end
      if (in_tvalid && in_tready) due_results.push_back(parse_item(in_tuser, in_tdata));
    end
    pending = due_results.size();
  end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Top of the NMEA field extractor bench: clock, reset, stimulus and verdict.
module tb_top;
  import nsfe_pkg::*;

  // The watchdog fires after this many cycles without any transfer.
  localparam int QUIET_LIMIT = 1000;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  logic [IN_TDATA_W-1:0]   in_tdata = '0;
  logic                    in_tuser = 1'b0;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  out_tdata;
  logic                    out_tuser;
  logic                    out_tlast;
  logic                    cfg_we = 1'b0;
  logic [CFGA_W-1:0]       cfg_addr = '0;
  logic [SEL_W-1:0]        cfg_wdata = '0;

  int fail_count;
  int pending;
  int quiet_cycles = 0;
  int item_count = 0;
  int gap_pct = 19;
  int stall_pct = 45;
  int read_pct = 0;
  int next_retune = 0;

  // What the bench has written into each slot register so far.
  logic [SEL_W-1:0] cur_sel [ALL_SLOTS];

  always #5 clk = ~clk;

  nmea_sentence_field_extractor dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  nsfe_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // The receiver stalls at random on each cycle, at the rate of the phase.
  always @(negedge clk) out_tready <= ($urandom_range(0, 99) >= stall_pct);

  // Any transfer on either channel restarts the quiet-cycle count.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // Offers one item and returns at the falling edge after its transfer.
  // Idle cycles are inserted first, each one at the sender's rate; otherwise
  // tvalid stays high from one item to the next.
  task automatic send_item(input logic act, input logic [7:0] b, input logic lerr,
                           input logic [RSLOT_W-1:0] rs, input logic [POS_W-1:0] rp);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {rp, rs, lerr, b};
    do @(posedge clk); while (!in_tready);
    item_count++;
    @(negedge clk);
  endtask

  // Reads hit the real slots most of the time, and now and then a slot that
  // does not exist or a position past any stored length. The line-error bit
  // and the byte are random since a read ignores them.
  task automatic send_random_read();
    logic [RSLOT_W-1:0] rs;
    logic [POS_W-1:0]   rp;
    rs = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
    rp = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(13, 15)) : 4'($urandom_range(0, 12));
    send_item(ACT_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), rs, rp);
  endtask

  // A received byte, with a rare line error and, at the read rate, a read
  // slipped in ahead of it.
  task automatic send_rx_byte(input logic [7:0] b);
    logic lerr;
    lerr = ($urandom_range(0, 59) == 0);
    if ($urandom_range(0, 99) < read_pct) send_random_read();
    send_item(ACT_RECEIVE, b, lerr, 3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)));
  endtask

  // Field content: mostly digits and a decimal point, sometimes any byte but
  // the delimiters, and once in a while any byte at all.
  function automatic logic [7:0] field_char();
    int         pick;
    logic [7:0] c;
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      c = 8'($urandom_range(0, 255));
    end else if (pick < 4) begin
      do c = 8'($urandom_range(0, 255)); while (c == CH_COMMA || c == CH_STAR);
    end else if (pick < 17) begin
      c = 8'h30 + 8'($urandom_range(0, 9));
    end else begin
      c = 8'h2E;
    end
    return c;
  endfunction

  // One sentence as a receiver sends it: "$GP", the tag, a comma, up to 16
  // fields, then '*', a checksum and CR LF. A tag or the comma after it is
  // broken now and then, so the parser has to recover.
  task automatic send_sentence();
    logic [7:0] tag [3];
    logic [7:0] sep;
    logic       is_rmc;
    int         nf;
    int         len;
    is_rmc = 1'($urandom_range(0, 1));
    tag[0] = is_rmc ? CH_R : CH_G;
    tag[1] = is_rmc ? CH_M : CH_G;
    tag[2] = is_rmc ? CH_C : CH_A;
    if ($urandom_range(0, 9) == 0) tag[$urandom_range(0, 2)] = 8'($urandom_range(0, 255));
    sep = ($urandom_range(0, 14) == 0) ? 8'($urandom_range(0, 255)) : CH_COMMA;
    send_rx_byte(8'h24);
    send_rx_byte(CH_G);
    send_rx_byte(8'h50);
    for (int i = 0; i < 3; i++) send_rx_byte(tag[i]);
    send_rx_byte(sep);
    nf = $urandom_range(0, 16);
    for (int f = 0; f < nf; f++) begin
      if (f != 0) send_rx_byte(CH_COMMA);
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 16) : $urandom_range(0, 6);
      repeat (len) send_rx_byte(field_char());
    end
    send_rx_byte(CH_STAR);
    send_rx_byte(8'h30 + 8'($urandom_range(0, 9)));
    send_rx_byte(8'h41 + 8'($urandom_range(0, 5)));
    send_rx_byte(8'h0D);
    send_rx_byte(8'h0A);
  endtask

  // Lets every outstanding result come back, then a few more cycles for the
  // two-stage pipeline, so that the block is idle.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // One register write; callers drop cfg_we once their last write is done.
  task automatic write_reg(input int idx, input logic [SEL_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx[CFGA_W-1:0];
    cfg_wdata <= value;
    if (idx < ALL_SLOTS) cur_sel[idx] = value;
    @(negedge clk);
  endtask

  // Writes every slot register from cur_sel, plus the two unused indexes,
  // which the block must ignore.
  task automatic load_selections();
    for (int i = 0; i < ALL_SLOTS; i++) write_reg(i, cur_sel[i]);
    write_reg(6, 5'($urandom_range(0, 31)));
    write_reg(7, 5'($urandom_range(0, 31)));
    cfg_we <= 1'b0;
  endtask

  // Mostly a live field of the first nine, sometimes disabled or the top code.
  function automatic logic [SEL_W-1:0] random_selection();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return 5'd0;
    if (pick == 1) return 5'd31;
    return {1'($urandom_range(0, 1)), 4'($urandom_range(1, 9))};
  endfunction

  // Retargets one register between sentences; for a slot register, a quarter of
  // the time it gets the value it already holds, which must leave the slot untouched.
  task automatic retune_one();
    int idx;
    wait_idle();
    idx = $urandom_range(0, 7);
    if (idx < ALL_SLOTS && $urandom_range(0, 3) == 0) write_reg(idx, cur_sel[idx]);
    else write_reg(idx, random_selection());
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input int upto);
    while (item_count < upto) begin
      if (item_count >= next_retune) begin
        retune_one();
        next_retune = item_count + 60;
      end
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 5)) send_rx_byte(8'($urandom_range(0, 255)));
      end else begin
        send_sentence();
      end
    end
  endtask

  // Tag, comma, then enough commas to run the field counter into saturation.
  task automatic send_counter_overflow();
    send_item(ACT_RECEIVE, CH_G, 1'b0, '0, '0);
    send_item(ACT_RECEIVE, CH_G, 1'b0, '0, '0);
    send_item(ACT_RECEIVE, CH_A, 1'b0, '0, '0);
    repeat (259) send_item(ACT_RECEIVE, CH_COMMA, 1'b0, '0, '0);
    send_item(ACT_RECEIVE, CH_STAR, 1'b0, '0, '0);
  endtask

  initial begin
    logic [7:0] long_field [14];
    for (int i = 0; i < ALL_SLOTS; i++) cur_sel[i] = '0;
    cur_sel[2] = 5'd1;
    long_field = '{8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
                   8'h37, 8'h38, 8'h39, 8'h2E, 8'h4E, 8'hFF, 8'h45};

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, with the reset selections: long slot 2 takes GGA field 1.
    // A byte with a line error is dropped; "GR" breaks the tag and the R must
    // not start a new one. The field then carries 14 characters, including
    // the byte extremes, so the last one overflows the long slot.
    send_item(ACT_RECEIVE, CH_G, 1'b1, '0, '0);
    send_item(ACT_RECEIVE, CH_G, 1'b0, '0, '0);
    send_item(ACT_RECEIVE, CH_R, 1'b0, '0, '0);
    send_item(ACT_RECEIVE, CH_G, 1'b0, '0, '0);
    send_item(ACT_RECEIVE, CH_G, 1'b0, '0, '0);
    send_item(ACT_RECEIVE, CH_A, 1'b0, '0, '0);
    send_item(ACT_RECEIVE, CH_COMMA, 1'b0, '0, '0);
    for (int i = 0; i < 14; i++) send_item(ACT_RECEIVE, long_field[i], 1'b0, '0, '0);
    send_item(ACT_RECEIVE, CH_STAR, 1'b0, '0, '0);
    // Last stored character, a position past the length, a short slot still
    // at '?', and a slot number with no slot behind it.
    send_item(ACT_READ, 8'hFF, 1'b1, 3'd2, 4'd12);
    send_item(ACT_READ, 8'h00, 1'b0, 3'd2, 4'd13);
    send_item(ACT_READ, 8'h00, 1'b0, 3'd3, 4'd15);
    send_item(ACT_READ, 8'h00, 1'b0, 3'd7, 4'd0);

    // Phase one: sender idles now and then, receiver stalls often. The
    // selections start at the extremes: disabled and RMC field 15.
    wait_idle();
    cur_sel[0] = 5'd2;
    cur_sel[1] = 5'd17;
    cur_sel[2] = 5'd31;
    cur_sel[3] = 5'd0;
    cur_sel[4] = 5'd18;
    cur_sel[5] = 5'd4;
    load_selections();
    read_pct = 12;
    next_retune = item_count + 60;
    run_phase(75);

    // Phase two: the other way round.
    wait_idle();
    gap_pct = 45;
    stall_pct = 19;
    for (int i = 0; i < ALL_SLOTS; i++) cur_sel[i] = random_selection();
    load_selections();
    run_phase(115);

    // Phase three: full rate on both sides, with the counter overflow first.
    wait_idle();
    gap_pct = 0;
    stall_pct = 0;
    for (int i = 0; i < ALL_SLOTS; i++) cur_sel[i] = random_selection();
    load_selections();
    send_counter_overflow();
    run_phase(420);

    wait_idle();
    repeat (6) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
